// File: sv/spq_pkg.sv
// Package for the sorted priority queue: field widths, operation and status
// codes, and the control bundle broadcast from the top level to every cell.
// No dependencies.
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // operation codes carried in in_tuser
  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  // status codes carried in out_tuser
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [DATA_W-1:0] DATA_EMPTY = -32'sd1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PRIO_W-1:0] prio_t;

  // broadcast control for one transaction
  typedef struct packed {
    logic  enq;
    logic  deq;
    data_t new_data;
    prio_t new_prio;
  } cell_ctl_t;

endpackage

// File: sv/spq_cell.sv
// One slot of the sorted queue chain: holds a payload and a priority and
// shifts toward the tail on insert or toward the head on removal.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,       // slot holds a live entry
  input  logic      prev_ge,   // head-side neighbor stays in place on insert
  input  data_t     prev_data,
  input  prio_t     prev_prio,
  input  data_t     next_data,
  input  prio_t     next_prio,
  output logic      ge,
  output data_t     data,
  output prio_t     prio
);

  data_t data_r, data_nxt;
  prio_t prio_r, prio_nxt;

  // live entry that ranks ahead of or ties with the incoming one
  assign ge = occ && (prio_r >= ctl.new_prio);

  // shift and insert selection
  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (ctl.enq && !ge) begin
      if (prev_ge) begin
        data_nxt = ctl.new_data;
        prio_nxt = ctl.new_prio;
      end else begin
        data_nxt = prev_data;
        prio_nxt = prev_prio;
      end
    end else if (ctl.deq) begin
      data_nxt = next_data;
      prio_nxt = next_prio;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule

// File: sv/sorted_priority_queue_core.sv
// Sorted priority queue: a chain of CAPACITY cells kept in descending
// priority order, ties first in, first out. Depends on spq_pkg, spq_cell.
//
// Input channel (in_*): one transaction per operation. in_tuser holds the
// kind (enqueue, dequeue, peek; the spare code does nothing). in_tdata holds
// the payload and the priority of an enqueue.
// Result channel (out_*): exactly one transaction per input transaction, in
// order. out_tdata holds the front payload (-1 when empty, 0 on enqueue) and
// the occupancy after the operation; out_tuser holds the status.
// The result is registered at the edge that accepts the operation. One
// operation per cycle is taken while the result register is free or being
// drained; every cell compares its priority with the incoming one in parallel
// and shifts in the same cycle, so the cell chain sets the rate.
// Reset clears the entry count and the result valid flag; cell contents and
// the result payload stay undefined until written and are never read before.
// When the receiver stalls, the result waits in the output register and
// in_tready drops until it is taken; in_tready stays high in a cycle where
// the waiting result leaves.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] data, [47:32] priority_req
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] out_data, [36:32] occupancy, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  data_t         out_data_r, out_data_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [OCC_W-1:0]  occ_out_r, occ_out_nxt;

  logic          accept;
  logic          full, empty;
  cell_ctl_t     ctl;
  logic [CW+OCC_W-1:0] count_ext;

  logic  [CAPACITY-1:0] occ;
  logic  [CAPACITY-1:0] ge;
  data_t                cdata [CAPACITY];
  prio_t                cprio [CAPACITY];

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign full      = (count_r >= CW'(CAPACITY));
  assign empty     = (count_r == '0);

  // operation decode and result selection
  always_comb begin
    ctl.enq      = 1'b0;
    ctl.deq      = 1'b0;
    ctl.new_data = data_t'(in_tdata[DATA_W-1:0]);
    ctl.new_prio = prio_t'(in_tdata[DATA_W+PRIO_W-1:DATA_W]);
    count_nxt    = count_r;
    out_data_nxt = '0;
    status_nxt   = ST_OK;
    case (in_tuser)
      KIND_ENQ: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.enq   = accept;
          if (accept) count_nxt = count_r + CW'(1);
        end
      end
      KIND_DEQ, KIND_PEEK: begin
        if (empty) begin
          out_data_nxt = DATA_EMPTY;
          status_nxt   = ST_EMPTY;
        end else begin
          out_data_nxt = cdata[0];
          if (in_tuser == KIND_DEQ && accept) begin
            ctl.deq   = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
    count_ext   = {{OCC_W{1'b0}}, count_nxt};
    occ_out_nxt = count_ext[OCC_W-1:0];
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      status_r   <= status_nxt;
      occ_out_r  <= occ_out_nxt;
    end
  end

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic  pge;
    data_t pdata, ndata;
    prio_t pprio, nprio;

    assign occ[g] = (count_r > CW'(g));

    if (g == 0) begin : g_head
      assign pge   = 1'b1;
      assign pdata = cdata[g];
      assign pprio = cprio[g];
    end else begin : g_mid
      assign pge   = ge[g-1];
      assign pdata = cdata[g-1];
      assign pprio = cprio[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign ndata = cdata[g];
      assign nprio = cprio[g];
    end else begin : g_body
      assign ndata = cdata[g+1];
      assign nprio = cprio[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[g]),
      .prev_ge   (pge),
      .prev_data (pdata),
      .prev_prio (pprio),
      .next_data (ndata),
      .next_prio (nprio),
      .ge        (ge[g]),
      .data      (cdata[g]),
      .prio      (cprio[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, occ_out_r, out_data_r};
  assign out_tuser  = status_r;

endmodule

// File: bench/sorted_queue_checker.sv
// Checker for the sorted priority queue: watches both stream channels, keeps a
// shadow of the queue contents, predicts each result and compares it.
// Depends on spq_pkg.
module sorted_queue_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] data, [47:32] priority_req
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] out_data, [36:32] occupancy, [39:37] zero
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          mismatches,
  output int          pending
);

  localparam int PRINT_LIMIT = 20;

  typedef struct packed {
    data_t               payload;
    logic [STAT_W-1:0]   status;
    logic [OCC_W-1:0]    occupancy;
  } queue_result_t;

  // shadow copy of the queue, front at index 0
  data_t         shadow_data [CAPACITY];
  prio_t         shadow_prio [CAPACITY];
  int            shadow_count;
  queue_result_t expected_results[$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    shadow_count = 0;
  end

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  // apply one operation to the shadow queue and return its result
  function automatic queue_result_t apply_queue_op(input logic [KIND_W-1:0] kind,
                                                   input data_t data, input prio_t prio);
    queue_result_t r;
    int pos;
    r.payload = '0;
    r.status  = ST_OK;
    case (kind)
      KIND_ENQ: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_data[i] = shadow_data[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_data[pos] = data;
          shadow_prio[pos] = prio;
          shadow_count++;
        end
      end
      KIND_DEQ, KIND_PEEK: begin
        if (shadow_count == 0) begin
          r.payload = DATA_EMPTY;
          r.status  = ST_EMPTY;
        end else begin
          r.payload = shadow_data[0];
          if (kind == KIND_DEQ) begin
            for (int i = 1; i < shadow_count; i++) begin
              shadow_data[i-1] = shadow_data[i];
              shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
          end
        end
      end
      default: ;  // spare code leaves the queue alone
    endcase
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // result check first, since a result never belongs to the operation taken at the same edge
  always @(posedge clk) begin : watch
    queue_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[31:0] !== want.payload)
            flag_mismatch("out_data", out_tdata[31:0], want.payload);
          if (out_tdata[36:32] !== want.occupancy)
            flag_mismatch("occupancy", out_tdata[36:32], want.occupancy);
          if (out_tdata[39:37] !== 3'b000)
            flag_mismatch("tdata padding", out_tdata[39:37], 0);
          if (out_tuser !== want.status)
            flag_mismatch("status", out_tuser, want.status);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_queue_op(in_tuser, in_tdata[31:0], in_tdata[47:32]));
    end
    pending = expected_results.size();
  end

endmodule

// File: bench/tb_sorted_priority_queue_core.sv
// Top of the sorted priority queue bench: clock, reset, operation stimulus,
// result back-pressure and the verdict. Depends on spq_pkg,
// sorted_priority_queue_core and sorted_queue_checker.
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int                CAPACITY     = 16;
  localparam int                RANDOM_ITEMS = 850;
  localparam int                CYCLE_LIMIT  = 400000;
  localparam int                DRAIN_CYCLES = 8;
  localparam int                HOLD_CYCLES  = 300;
  localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;  // [31:0] data, [47:32] priority_req
  logic [1:0]  in_tuser   = '0;  // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [31:0] out_data, [36:32] occupancy, [39:37] zero
  logic [1:0]  out_tuser;        // [1:0] status
  int          mismatches;
  int          pending;
  int          cycle_count = 0;

  sorted_priority_queue_core #(.CAPACITY(CAPACITY)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sorted_queue_checker #(.CAPACITY(CAPACITY)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one operation and hold it until the transaction completes
  task automatic send_op(input logic [KIND_W-1:0] kind, input data_t data, input prio_t prio);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {prio, data};
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver: stretches of differing stall density, plus one long hold-off
  initial begin : receiver
    int stretch;
    int mode;
    int stretch_idx;
    stretch_idx = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (stretch_idx == 8) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stretch = $urandom_range(10, 80);
      mode    = $urandom_range(0, 3);
      repeat (stretch) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 0);
          2: out_tready <= ($urandom_range(0, 4) == 0);
          default: out_tready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
      end
      stretch_idx++;
    end
  end

  // reset, directed operations, random bursts, drain and verdict
  initial begin : stimulus
    int                sent;
    int                burst_len;
    int                gap;
    int                phase_left;
    int                pick;
    bit                fill_phase;
    logic [KIND_W-1:0] kind;
    prio_t             prio;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (!rst_n) @(posedge clk);

    // empty queue: peek, dequeue and the spare code
    send_op(KIND_PEEK, 32'sd7, 16'sd1);
    send_op(KIND_DEQ, 32'sd7, 16'sd1);
    send_op(KIND_NOP, 32'sd9, 16'sd2);
    // extremes of payload and priority, and a tie at zero
    send_op(KIND_ENQ, 32'sh7fffffff, 16'sh7fff);
    send_op(KIND_ENQ, 32'sh80000000, 16'sh8000);
    send_op(KIND_ENQ, 32'sd0, 16'sd0);
    send_op(KIND_ENQ, -32'sd1, 16'sd0);
    send_op(KIND_PEEK, 32'sd0, 16'sd0);
    send_op(KIND_DEQ, 32'sd0, 16'sd0);
    send_op(KIND_DEQ, 32'sd0, 16'sd0);
    // fill to capacity, then one enqueue that must be dropped
    for (int i = 0; i < CAPACITY - 2; i++)
      send_op(KIND_ENQ, data_t'($urandom), prio_t'(i % 3 - 1));
    send_op(KIND_ENQ, 32'sh12345678, 16'sh7fff);
    send_op(KIND_PEEK, 32'sd0, 16'sd0);

    // random bursts, alternating fill-biased and drain-biased phases
    sent       = 0;
    fill_phase = 1'b0;
    phase_left = 60;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 24);
      for (int b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
        pick = $urandom_range(0, 99);
        if (fill_phase)
          kind = (pick < 65) ? KIND_ENQ : (pick < 85) ? KIND_DEQ :
                 (pick < 95) ? KIND_PEEK : KIND_NOP;
        else
          kind = (pick < 20) ? KIND_ENQ : (pick < 80) ? KIND_DEQ :
                 (pick < 95) ? KIND_PEEK : KIND_NOP;
        // mostly narrow priorities so ties are common, some full range and extremes
        pick = $urandom_range(0, 9);
        if (pick < 5)
          prio = prio_t'($urandom_range(0, 6)) - 16'sd3;
        else if (pick < 9)
          prio = prio_t'($urandom);
        else
          prio = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        send_op(kind, data_t'($urandom), prio);
        sent++;
        if (--phase_left == 0) begin
          fill_phase = !fill_phase;
          phase_left = $urandom_range(40, 80);
        end
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    // wait for outstanding results, then a further wait of DRAIN_CYCLES for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_core.sv
bench/sorted_queue_checker.sv
bench/tb_sorted_priority_queue_core.sv
